// ===== rtl/core/sha2he_pkg.sv =====
// shared types, constants and tables of the sha-256 / sha-224 hash engine
package sha2he_pkg;

  localparam int IQ_DEPTH_DEF = 4;
  localparam int OQ_DEPTH     = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // back end to result queue
  typedef struct packed {
    logic      push;
    out_item_t item;
  } oq_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } bk_state_t;

  // initial hash value, sha-256 when mode is set, otherwise sha-224
  function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] idx);
    logic [31:0] w;
    if (mode) begin
      case (idx)
        3'd0: w = 32'h6A09E667;
        3'd1: w = 32'hBB67AE85;
        3'd2: w = 32'h3C6EF372;
        3'd3: w = 32'hA54FF53A;
        3'd4: w = 32'h510E527F;
        3'd5: w = 32'h9B05688C;
        3'd6: w = 32'h1F83D9AB;
        3'd7: w = 32'h5BE0CD19;
        default: w = '0;
      endcase
    end else begin
      case (idx)
        3'd0: w = 32'hc1059ed8;
        3'd1: w = 32'h367cd507;
        3'd2: w = 32'h3070dd17;
        3'd3: w = 32'hf70e5939;
        3'd4: w = 32'hffc00b31;
        3'd5: w = 32'h68581511;
        3'd6: w = 32'h64f98fa7;
        3'd7: w = 32'hbefa4fa4;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/sha2he_front.sv =====
// front end: input transaction queue between the ports and the hash core
module sha2he_front
  import sha2he_pkg::*;
#(
  parameter int DEPTH = IQ_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t din,
  input  logic     pop,
  output logic     valid,
  output in_item_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  in_item_t        mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== rtl/core/sha2he_outq.sv =====
// result queue holding digest words until they are taken
module sha2he_outq
  import sha2he_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  oq_wr_t    wr,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t dout
);

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  out_item_t     mem_r [OQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(OQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;

  // pointers wrap naturally at a power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr.item;
    end
  end

endmodule

// ===== rtl/core/sha2he_back.sv =====
// back end: block packing, padding, 64-round compression and digest output
module sha2he_back
  import sha2he_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     item_pop,
  input  logic     oq_empty,
  output oq_wr_t   oq_wr
);

  bk_state_t   state_r, state_nxt;
  logic        mode_r;
  logic [5:0]  pos_r;
  logic [63:0] bitcnt_r;
  logic [5:0]  rnd_r;
  logic [2:0]  emit_r;
  logic        fin_r, first_r, lenph_r;
  logic [31:0] win_r  [16];
  logic [31:0] hash_r [8];
  logic [31:0] v_r    [8];

  logic        wr_byte, absorb, start_fin, emit_go, emit_last;
  logic [7:0]  wbyte, len_byte;
  logic [4:0]  boff;
  logic [31:0] t1, t2, w_new, ch, maj, e, a;
  logic [2:0]  last_idx;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign e        = v_r[4];
  assign a        = v_r[0];
  assign ch       = (e & v_r[5]) ^ (~e & v_r[6]);
  assign maj      = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1       = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
                    + round_k(rnd_r) + win_r[0];
  assign t2       = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
  assign w_new    = (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10))
                    + win_r[9]
                    + (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3))
                    + win_r[0];
  assign len_byte = bitcnt_r[{~pos_r[2:0], 3'b000} +: 8];
  assign boff     = {~pos_r[1:0], 3'b000};
  assign last_idx = mode_r ? 3'd7 : 3'd6;
  assign emit_last = (emit_r == last_idx);

  // next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    item_pop  = 1'b0;
    absorb    = 1'b0;
    start_fin = 1'b0;
    wr_byte   = 1'b0;
    wbyte     = item.data_byte;
    emit_go   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!cfg_we && item_valid) begin
          item_pop = 1'b1;
          if (item.command == CMD_ABSORB) begin
            absorb  = 1'b1;
            wr_byte = 1'b1;
            if (pos_r == LAST_POS) begin
              state_nxt = ST_ROUND;
            end
          end else begin
            start_fin = 1'b1;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_byte = 1'b1;
        if (first_r) begin
          wbyte = PAD_BYTE;
        end else if (lenph_r || pos_r == LEN_POS) begin
          wbyte = len_byte;
        end else begin
          wbyte = '0;
        end
        if (pos_r == LAST_POS) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (fin_r && lenph_r) begin
          state_nxt = ST_EMIT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        emit_go = (emit_r != '0) || oq_empty;
        if (emit_go && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign oq_wr.push             = emit_go;
  assign oq_wr.item.digest_word = hash_r[emit_r];
  assign oq_wr.item.word_index  = emit_r;
  assign oq_wr.item.last_word   = emit_last;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= 1'b1;
      pos_r    <= '0;
      bitcnt_r <= '0;
      rnd_r    <= '0;
      emit_r   <= '0;
      fin_r    <= 1'b0;
      first_r  <= 1'b0;
      lenph_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (wr_byte) begin
        pos_r <= pos_r + 1'b1;
      end
      if (absorb) begin
        bitcnt_r <= bitcnt_r + 64'd8;
      end
      if (start_fin) begin
        fin_r   <= 1'b1;
        first_r <= 1'b1;
        lenph_r <= 1'b0;
      end else if (state_r == ST_PAD) begin
        first_r <= 1'b0;
        if (!first_r && pos_r == LEN_POS) begin
          lenph_r <= 1'b1;
        end
      end
      if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 1'b1;
      end else begin
        rnd_r <= '0;
      end
      if (emit_go) begin
        emit_r <= emit_last ? '0 : emit_r + 1'b1;
      end
      // restart after the digest or on a mode write
      if ((emit_go && emit_last) || cfg_we) begin
        pos_r    <= '0;
        bitcnt_r <= '0;
        fin_r    <= 1'b0;
        lenph_r  <= 1'b0;
      end
    end
  end

  // message window: bytes pack into it, rounds shift the schedule through it
  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w_new;
    end else if (wr_byte) begin
      win_r[pos_r[5:2]][boff +: 8] <= wbyte;
    end
  end

  // working variables a..h
  always_ff @(posedge clk) begin
    if (state_r != ST_ROUND) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= hash_r[i];
      end
    end else begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // chaining hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= iv_word(1'b1, 3'(i));
      end
    end else if (cfg_we) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= iv_word(cfg_wdata, 3'(i));
      end
    end else if (emit_go && emit_last) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= iv_word(mode_r, 3'(i));
      end
    end else if (state_r == ST_ADD) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

endmodule

// ===== rtl/core/sha256_sha224_hash_engine_unit.sv =====
// sha-256 / sha-224 byte-stream hash engine, top level
// absorb transaction: every 64th byte starts a 64-round compression and the add step
// byte intake pauses while the single shared round unit compresses a block
// finish: padding byte by byte (spilling into a second block when needed), compression of
// each padded block, then 7 or 8 result words, one per cycle once the
// result queue has drained
// reset: synchronous active low; sha-256 mode, sha-256 initial hash, empty queues
module sha256_sha224_hash_engine_unit
  import sha2he_pkg::*;
#(
  parameter int IQ_DEPTH = IQ_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic     fq_valid, bk_pop, oq_full;
  in_item_t fq_item;
  oq_wr_t   oq_wr;

  sha2he_front #(.DEPTH(IQ_DEPTH)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .din   (in_item),
    .pop   (bk_pop),
    .valid (fq_valid),
    .dout  (fq_item)
  );

  sha2he_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (fq_valid),
    .item       (fq_item),
    .item_pop   (bk_pop),
    .oq_empty   (out_empty),
    .oq_wr      (oq_wr)
  );

  sha2he_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (oq_wr),
    .full  (oq_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (out_item)
  );

  // the core never writes a digest word into a full result queue
  a_no_oq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_wr.push |-> !oq_full)
    else $error("digest word pushed into full result queue");

  // the core only takes a transaction the front queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> fq_valid)
    else $error("core popped an empty front queue");

  // results queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

// ===== bench/tb_sha256_sha224_hash_engine_unit.sv =====
// self-checking testbench for the sha-256 / sha-224 byte-stream hash engine
`timescale 1ns / 1ps

module tb_sha256_sha224_hash_engine_unit;
  import sha2he_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLD_CYCLES    = 500;
  localparam int ITEM_TARGET    = 330;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  sha256_sha224_hash_engine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // hash state mirrored by the predictor
  logic        sha256_mode;
  logic [31:0] chain_words [8];
  logic [7:0]  msg_block [64];
  int          fill_count;
  logic [63:0] msg_bits;

  in_item_t  byte_stream [$];
  out_item_t digest_words [$];
  int        mismatch_count;
  bit        calm_mode;
  int        words_seen;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // restart message with the current mode's initial hash
  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_words[i] = iv_word(sha256_mode, 3'(i));
    fill_count = 0;
    msg_bits   = '0;
  endtask

  // one 64-round compression of msg_block into chain_words
  task automatic compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
      s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
      sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(t)) + sched[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] += v[i];
  endtask

  // absorb a byte or pad, compress and queue the expected digest words
  task automatic hash_transaction(input in_item_t it);
    int        pos;
    int        n;
    out_item_t w;
    if (it.command == CMD_ABSORB) begin
      msg_block[fill_count] = it.data_byte;
      fill_count++;
      msg_bits += 64'd8;
      if (fill_count == 64) begin
        compress_block();
        fill_count = 0;
      end
    end else begin
      pos = fill_count;
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin msg_block[pos] = 8'h00; pos++; end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin msg_block[pos] = 8'h00; pos++; end
      for (int i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
      compress_block();
      n = sha256_mode ? 8 : 7;
      for (int i = 0; i < n; i++) begin
        w.digest_word = chain_words[i];
        w.word_index  = 3'(i);
        w.last_word   = (i == n - 1);
        digest_words.push_back(w);
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // prediction on accepted transactions and configuration writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sha256_mode = cfg_wdata;
        restart_hash();
      end
      if (in_push && !in_full) hash_transaction(in_item);
    end
  end

  // driver with random idle bursts
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else if (!in_push || !in_full) begin
      if (send_gap > 0) begin
        in_push  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (byte_stream.size() > 0 && !calm_mode && $urandom_range(0, 9) == 0) begin
        in_push  <= 1'b0;
        send_gap <= $urandom_range(0, 5);
      end else if (byte_stream.size() > 0) begin
        in_push <= 1'b1;
        in_item <= byte_stream.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: checks each popped word, stalls in bursts, one long hold
  int  stall_left;
  bit  held_once;
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_pop    <= 1'b0;
      stall_left <= 0;
      held_once  <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        words_seen++;
        if (digest_words.size() == 0) begin
          report_mismatch("unexpected word", out_item.digest_word, 32'h0);
        end else begin
          want = digest_words.pop_front();
          if (out_item.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_item.digest_word, want.digest_word);
          if (out_item.word_index !== want.word_index)
            report_mismatch("word_index", 32'(out_item.word_index), 32'(want.word_index));
          if (out_item.last_word !== want.last_word)
            report_mismatch("last_word", 32'(out_item.last_word), 32'(want.last_word));
        end
      end
      if (!held_once && words_seen >= 20) begin
        held_once  <= 1'b1;
        stall_left <= HOLD_CYCLES;
        out_pop    <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_pop    <= 1'b0;
      end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_pop    <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted transaction, popped word or mode write
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    in_item_t it;
    it.command   = CMD_ABSORB;
    it.data_byte = b;
    byte_stream.push_back(it);
  endtask

  task automatic queue_finish();
    in_item_t it;
    it.command   = CMD_FINISH;
    it.data_byte = 8'($urandom_range(0, 255));
    byte_stream.push_back(it);
  endtask

  // whole message of random bytes, lengths biased to padding boundaries
  task automatic queue_message(output int len);
    case ($urandom_range(0, 9))
      0: len = 55;
      1: len = 56;
      2: len = 63 + $urandom_range(0, 2);
      3: len = $urandom_range(0, 130);
      default: len = $urandom_range(0, 20);
    endcase
    for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
    queue_finish();
    len++;
  endtask

  // wait until the engine has drained, then write the mode
  task automatic set_mode(input logic m);
    while (byte_stream.size() > 0 || in_push || digest_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    int         sent;
    int         len;
    logic [1:0] modes [4];
    modes = '{1'b0, 1'b1, 1'b0, 1'b1};
    mismatch_count = 0;
    words_seen     = 0;
    calm_mode      = 1'b0;
    in_push        = 1'b0;
    in_item        = '0;
    out_pop        = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b1;
    sha256_mode    = 1'b1;
    restart_hash();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, extreme bytes, a short message, both modes
    queue_finish();
    queue_byte(8'h00); queue_byte(8'hFF); queue_finish();
    queue_byte(8'h61); queue_byte(8'h62); queue_byte(8'h63); queue_finish();
    set_mode(1'b0);
    queue_finish();
    queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'h80); queue_finish();
    // partial message then a mode write drops it
    queue_byte(8'h5A); queue_byte(8'hA5);
    set_mode(1'b1);
    queue_byte(8'h01); queue_finish();
    sent = 18;

    // random messages over several mode settings
    for (int p = 0; p < 4; p++) begin
      set_mode(modes[p][0]);
      if (p == 3) calm_mode = 1'b1;
      while (sent < ITEM_TARGET * (p + 1) / 4) begin
        queue_message(len);
        sent += len;
      end
      // trailing bytes left unfinished, dropped by the next mode write
      if (p < 3) for (int i = $urandom_range(0, 10); i > 0; i--) queue_byte(8'($urandom));
    end

    while (byte_stream.size() > 0 || in_push || digest_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
